FILE: hdl/lamp_panel_visual_tracker_top_assert.svh
// Assertion macros for the lamp and panel visual tracker.
`ifndef LAMP_PANEL_VISUAL_TRACKER_TOP_ASSERT_SVH
`define LAMP_PANEL_VISUAL_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPVT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LPVT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LPVT_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPVT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/lpvt_pkg.sv
// Shared types and constants for the lamp and panel visual tracker.
`timescale 1ns / 1ps
package lpvt_pkg;
   localparam int unsigned DOOR_FRAMES_DEF = 16;
   localparam int unsigned HOOD_FRAMES_DEF = 14;
   localparam int unsigned MAX_GAP_MS_DEF  = 2000;
   localparam logic [20:0] FULL_OPEN = 21'd1048576;
   localparam logic [20:0] ZERO_RATE_SUB = 21'd1049;

   localparam logic [2:0] REG_LAMP_TO   = 3'd0;
   localparam logic [2:0] REG_PANEL_TO  = 3'd1;
   localparam logic [2:0] REG_DOOR_OPEN = 3'd2;
   localparam logic [2:0] REG_DOOR_CLS  = 3'd3;
   localparam logic [2:0] REG_HOOD_OPEN = 3'd4;
   localparam logic [2:0] REG_HOOD_CLS  = 3'd5;

   localparam logic [2:0] MOT_UNKNOWN = 3'd0;
   localparam logic [2:0] MOT_CLOSED  = 3'd1;
   localparam logic [2:0] MOT_OPENING = 3'd2;
   localparam logic [2:0] MOT_OPEN    = 3'd3;
   localparam logic [2:0] MOT_CLOSING = 3'd4;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic       store;    // latch a report
      logic       start;    // capture tick time, lamps, elapsed
      logic       calc;     // stage 1 of a panel: freshness, multiply
      logic       apply;    // stage 2: move position, build result
      logic       finish;   // update previous tick time
      logic [2:0] panel;
   } cmd_type;
endpackage

FILE: hdl/lpvt_ctrl.sv
// Controller: sequences reports and the six panel steps of a tick.
`timescale 1ns / 1ps
`include "lamp_panel_visual_tracker_top_assert.svh"
module lpvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_tlast,
   output lpvt_pkg::cmd_type cmd
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_CALC  = 5'b00100,
      ST_APPLY = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] panel_ff, panel_in;
   logic       vld_ff, vld_in;
   logic       last_ff, last_in;
   logic       rsp_take;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_take   = vld_ff & rsp_tready;

   always_comb begin
      state_in = state_ff;
      panel_in = panel_ff;
      vld_in   = vld_ff & ~rsp_tready;
      last_in  = last_ff;
      cmd      = '0;
      cmd.panel = panel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == lpvt_pkg::OP_TICK) begin
                  state_in = ST_START;
                  cmd.start = 1'b1;
               end else begin
                  cmd.store = 1'b1;
               end
            end
            panel_in = 3'd0;
         end
         ST_START: state_in = ST_CALC;
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (!vld_ff || rsp_tready) begin
               cmd.apply = 1'b1;
               vld_in    = 1'b1;
               last_in   = (panel_ff == 3'd5);
               if (panel_ff == 3'd5) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  panel_in = panel_ff + 3'd1;
                  state_in = ST_CALC;
               end
            end
         end
         ST_OUT: begin
            if (rsp_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         panel_ff <= 3'd0;
         vld_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         panel_ff <= panel_in;
         vld_ff   <= vld_in;
         last_ff  <= last_in;
      end
   end

   `LPVT_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `LPVT_ASSERT_IMP(a_panel_rng, clock, reset, 1'b1, panel_ff <= 3'd5)
   `LPVT_ASSERT_NXT(a_apply_vld, clock, reset, cmd.apply, rsp_tvalid)
   `LPVT_ASSERT_IMP(a_idle_quiet, clock, reset, req_tready, !rsp_tvalid)
endmodule

FILE: hdl/lpvt_dp.sv
// Datapath: signal store, config registers, lamp logic and panel slew.
`timescale 1ns / 1ps
module lpvt_dp #(
   parameter int unsigned DOOR_FRAMES = lpvt_pkg::DOOR_FRAMES_DEF,
   parameter int unsigned HOOD_FRAMES = lpvt_pkg::HOOD_FRAMES_DEF,
   parameter int unsigned MAX_GAP_MS  = lpvt_pkg::MAX_GAP_MS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lpvt_pkg::cmd_type cmd,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic [3:0]        in_index,
   input  logic              in_value,
   input  logic              in_valid,
   input  logic              in_stale,
   input  logic [31:0]       in_stamp,
   output logic [44:0]       rsp_data
);
   localparam logic [31:0] GAP = 32'(MAX_GAP_MS);

   logic [31:0] lamp_to_ff, panel_to_ff;
   logic [20:0] rate_ff [4];
   logic [2:0]  flags_ff [12];
   logic [31:0] time_ff [12];
   logic [20:0] pos_ff [6];
   logic [2:0]  mot_ff [6];
   logic [5:0]  known_ff;
   logic [31:0] prev_ff;
   logic        seen_ff;
   logic [31:0] now_ff;
   logic [15:0] dt_ff;
   logic [5:0]  lit_ff, lknown_ff;

   // stage registers
   logic        fresh_ff, tgt_ff;
   logic [36:0] delta_ff;
   logic [44:0] out_ff;

   function automatic logic fresh(input logic [2:0] f, input logic [31:0] t,
                                  input logic [31:0] now, input logic [31:0] to);
      logic [31:0] age;
      age = (now > t) ? now - t : 32'd0;
      return f[1] & ~f[2] & (age <= to);
   endfunction

   // lamp bits
   logic [5:0] lk, ll;
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         lk[i] = fresh(flags_ff[i], time_ff[i], in_stamp, lamp_to_ff);
         ll[i] = lk[i] & flags_ff[i][0];
      end
      if (lk[3] & ll[3]) begin
         lk[2:1] = 2'b11;
         ll[2:1] = 2'b11;
      end
   end

   logic [31:0] dgap;
   assign dgap = in_stamp - prev_ff;

   // stage 1
   logic [3:0]  sig;
   logic        hood, tgt, up, fr;
   logic [20:0] pos, rsel, rate;
   assign sig  = 4'd6 + {1'b0, cmd.panel};
   assign hood = cmd.panel >= 3'd4;
   assign pos  = pos_ff[cmd.panel];
   assign tgt  = flags_ff[sig][0];
   assign up   = tgt & (pos < lpvt_pkg::FULL_OPEN);
   assign fr   = fresh(flags_ff[sig], time_ff[sig], now_ff, panel_to_ff);
   always_comb begin
      rsel = rate_ff[{hood, ~up}];
      rate = (rsel == 21'd0) ? lpvt_pkg::ZERO_RATE_SUB : rsel;
   end

   // stage 2
   logic [20:0] npos;
   logic [2:0]  nmot, omot;
   logic        nknown;
   logic [4:0]  frames_m1;
   logic [25:0] prod;
   logic [4:0]  frame;
   always_comb begin
      npos   = pos;
      nknown = 1'b0;
      omot   = known_ff[cmd.panel] ? mot_ff[cmd.panel] : lpvt_pkg::MOT_UNKNOWN;
      nmot   = (omot == lpvt_pkg::MOT_OPEN || omot == lpvt_pkg::MOT_CLOSED)
               ? omot : lpvt_pkg::MOT_UNKNOWN;
      if (fresh_ff) begin
         nknown = 1'b1;
         if (tgt_ff) begin
            if (pos < lpvt_pkg::FULL_OPEN)
               npos = ({16'd0, lpvt_pkg::FULL_OPEN} - {16'd0, pos} <= delta_ff)
                      ? lpvt_pkg::FULL_OPEN : pos + delta_ff[20:0];
         end else if (pos != 21'd0) begin
            npos = ({16'd0, pos} <= delta_ff) ? 21'd0 : pos - delta_ff[20:0];
         end
         if (npos == 21'd0) nmot = lpvt_pkg::MOT_CLOSED;
         else if (npos >= lpvt_pkg::FULL_OPEN) nmot = lpvt_pkg::MOT_OPEN;
         else nmot = tgt_ff ? lpvt_pkg::MOT_OPENING : lpvt_pkg::MOT_CLOSING;
      end
      frames_m1 = (cmd.panel >= 3'd4) ? 5'(HOOD_FRAMES - 1) : 5'(DOOR_FRAMES - 1);
      prod  = {5'd0, npos} * {21'd0, frames_m1} + 26'd524288;
      frame = prod[24:20];
      if (frame > frames_m1) frame = frames_m1;
      if (npos == 21'd0) frame = 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_to_ff  <= 32'd1000;
         panel_to_ff <= 32'd1000;
         rate_ff[0]  <= 21'd2097;
         rate_ff[1]  <= 21'd2097;
         rate_ff[2]  <= 21'd1808;
         rate_ff[3]  <= 21'd2097;
         for (int i = 0; i < 12; i++) begin
            flags_ff[i] <= 3'd0;
            time_ff[i]  <= 32'd0;
         end
         for (int i = 0; i < 6; i++) begin
            pos_ff[i] <= 21'd0;
            mot_ff[i] <= lpvt_pkg::MOT_UNKNOWN;
         end
         known_ff <= 6'd0;
         prev_ff  <= 32'd0;
         seen_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               lpvt_pkg::REG_LAMP_TO:   lamp_to_ff  <= csr_wdata;
               lpvt_pkg::REG_PANEL_TO:  panel_to_ff <= csr_wdata;
               lpvt_pkg::REG_DOOR_OPEN: rate_ff[0]  <= csr_wdata[20:0];
               lpvt_pkg::REG_DOOR_CLS:  rate_ff[1]  <= csr_wdata[20:0];
               lpvt_pkg::REG_HOOD_OPEN: rate_ff[2]  <= csr_wdata[20:0];
               lpvt_pkg::REG_HOOD_CLS:  rate_ff[3]  <= csr_wdata[20:0];
               default: ;
            endcase
         end
         if (cmd.store && in_index < 4'd12) begin
            flags_ff[in_index] <= {in_stale, in_valid, in_value};
            time_ff[in_index]  <= in_stamp;
         end
         if (cmd.apply) begin
            pos_ff[cmd.panel]   <= npos;
            mot_ff[cmd.panel]   <= nmot;
            known_ff[cmd.panel] <= nknown;
         end
         if (cmd.finish) begin
            prev_ff <= now_ff;
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         now_ff    <= in_stamp;
         lit_ff    <= ll;
         lknown_ff <= lk;
         if (!seen_ff || in_stamp <= prev_ff) dt_ff <= 16'd0;
         else dt_ff <= (dgap > GAP) ? 16'(MAX_GAP_MS) : dgap[15:0];
      end
      if (cmd.calc) begin
         fresh_ff <= fr;
         tgt_ff   <= tgt;
         delta_ff <= {16'd0, rate} * {21'd0, dt_ff};
      end
      if (cmd.apply)
         out_ff <= {lknown_ff, lit_ff, (npos != 21'd0),
                    frame[3:0], nknown, nmot, npos, cmd.panel};
   end

   assign rsp_data = out_ff;
endmodule

FILE: hdl/lamp_panel_visual_tracker_top.sv
// Top level of the lamp and panel visual tracker.
// channel | dir | tdata (low bit up)                             | tuser | tlast
// req     | in  | signal_index,value,valid,stale,stamp_ms       | op    | -
// rsp     | out | panel_index,position,motion,known,frame,visible,lit,known | - | last
// A report is latched as it is accepted. A tick runs as below, longer under stall:
// accept, a start cycle, then per panel a freshness/multiply step and a slew
// step on one shared slewer, and an output state to hand off the last result.
// Reset is synchronous; config registers return to their defaults.
// The result register holds under rsp stall; the next panel waits for it.
`timescale 1ns / 1ps
module lamp_panel_visual_tracker_top #(
   parameter int unsigned DOOR_FRAMES = lpvt_pkg::DOOR_FRAMES_DEF,
   parameter int unsigned HOOD_FRAMES = lpvt_pkg::HOOD_FRAMES_DEF,
   parameter int unsigned MAX_GAP_MS  = lpvt_pkg::MAX_GAP_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // index[3:0],value,valid,stale,stamp[38:7]
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // index,position,motion,known,frame,visible,lit,known
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   lpvt_pkg::cmd_type cmd;
   logic [44:0] data;

   lpvt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_op(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tlast(rsp_tlast), .cmd(cmd)
   );

   lpvt_dp #(.DOOR_FRAMES(DOOR_FRAMES), .HOOD_FRAMES(HOOD_FRAMES),
             .MAX_GAP_MS(MAX_GAP_MS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .in_index(req_tdata[3:0]),
      .in_value(req_tdata[4]), .in_valid(req_tdata[5]), .in_stale(req_tdata[6]),
      .in_stamp(req_tdata[38:7]), .rsp_data(data)
   );

   assign rsp_tdata = {3'd0, data};
endmodule
